// ===== rtl/fud_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fud_pkg
// Shared types and constants for the urlencoded form decoder with UTF-8
// text checking: item payloads, per-body decoder state, codes and helpers.
// ----------------------------------------------------------------------------
package fud_pkg;

   localparam int FIELD_COUNT_WIDTH = 8;
   localparam int LIMIT_WIDTH       = 8;
   localparam int CMP_WIDTH         = (FIELD_COUNT_WIDTH > LIMIT_WIDTH) ?
                                      FIELD_COUNT_WIDTH : LIMIT_WIDTH;

   localparam logic [LIMIT_WIDTH-1:0] FIELD_LIMIT_RESET = LIMIT_WIDTH'(16);

   // result kinds
   localparam logic [1:0] KIND_KEY       = 2'd0;
   localparam logic [1:0] KIND_VALUE     = 2'd1;
   localparam logic [1:0] KIND_FIELD_END = 2'd2;
   localparam logic [1:0] KIND_STATUS    = 2'd3;

   // body status
   localparam logic [1:0] ST_VALID     = 2'd0;
   localparam logic [1:0] ST_MALFORMED = 2'd1;
   localparam logic [1:0] ST_TOO_MANY  = 2'd2;

   // component part
   localparam logic [1:0] PART_KEY   = 2'd0;
   localparam logic [1:0] PART_VALUE = 2'd1;

   // escape phase
   localparam logic [1:0] ESC_NONE = 2'd0;
   localparam logic [1:0] ESC_HIGH = 2'd1;
   localparam logic [1:0] ESC_LOW  = 2'd2;

   // syntax characters
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_EQUAL   = 8'h3d;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2b;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   // text limits
   localparam logic [20:0] CP_MIN_2     = 21'h80;
   localparam logic [20:0] CP_MIN_3     = 21'h800;
   localparam logic [20:0] CP_MIN_4     = 21'h10000;
   localparam logic [20:0] CP_SURR_LO   = 21'hd800;
   localparam logic [20:0] CP_SURR_HI   = 21'hdfff;
   localparam logic [20:0] CP_MAX       = 21'h10ffff;

   typedef struct packed {
      logic [7:0] body_byte;
      logic       byte_present;
      logic       end_of_body;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] item_kind;
      logic [7:0] decoded_byte;
      logic [1:0] decode_status;
      logic       last_result;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]                   component_part;
      logic [1:0]                   escape_phase;
      logic [3:0]                   high_nibble;
      logic [1:0]                   utf8_remaining;
      logic [1:0]                   utf8_length;
      logic [20:0]                  partial_codepoint;
      logic                         key_nonempty;
      logic                         field_suppressed;
      logic [FIELD_COUNT_WIDTH-1:0] fields_taken;
      logic [1:0]                   error_status;
   } body_state_type;

   // hex digit decode, bit 4 set when the character is not a hex digit
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'h10;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b0, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b0, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b0, 4'(b - 8'h37)};
      end
      return r;
   endfunction

   function automatic rsp_payload_type make_rsp(input logic [1:0] kind,
                                                input logic [7:0] data,
                                                input logic [1:0] status,
                                                input logic       last);
      rsp_payload_type r;
      r.item_kind     = kind;
      r.decoded_byte  = data;
      r.decode_status = status;
      r.last_result   = last;
      return r;
   endfunction

endpackage

// ===== rtl/form_urldecode_utf8_check_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// form_urldecode_utf8_check_unit
// Streaming urlencoded form decoder: splits fields, decodes '+' and %HH,
// checks key and value text as UTF-8 and reports a final body status.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one raw body byte per item (byte_present, end_of_body flags).
//   rsp_*  : decoded key/value bytes, field-end markers and, after the last
//            item of a body, one final status item with last_result set.
//   csr_*  : write of field_limit, always ready; write only while idle.
// An accepted item is decoded in the cycle it is taken; its zero to three
// results land in a four-entry registered output queue whose head drives
// rsp_*. One item per cycle is taken as long as the queue holds at most
// one result; items giving one result each stream at one per cycle while
// the receiver does not stall. req_stall rises when the queue has fewer than
// three free entries, so an item ending a body (up to three results) costs
// extra cycles only while the receiver drains the queue.
// When the receiver stalls, the queue head holds and the queue fills; input
// stalls once it is nearly full. Reset empties the queue, clears the body
// state and sets field_limit to 16.
// ----------------------------------------------------------------------------
module form_urldecode_utf8_check_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  fud_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output fud_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [7:0]               csr_data
);

   localparam int QDEPTH = 4;
   localparam int PTR_W  = $clog2(QDEPTH);
   localparam int CNT_W  = $clog2(QDEPTH + 1);
   localparam int MAXRES = 3;

   logic [fud_pkg::LIMIT_WIDTH-1:0] field_limit_ff;
   fud_pkg::body_state_type         state_ff, state_in;

   fud_pkg::rsp_payload_type queue_ff [QDEPTH];
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]         count_ff, count_in;

   fud_pkg::rsp_payload_type res [MAXRES];
   logic [1:0]               res_n;

   logic req_accept;
   logic rsp_accept;

   // end of component then end of field
   function automatic fud_pkg::body_state_type close_field(
      input  fud_pkg::body_state_type         s,
      input  logic [fud_pkg::LIMIT_WIDTH-1:0] limit,
      output logic                            emit
   );
      fud_pkg::body_state_type t;
      logic                    full;
      t    = s;
      emit = 1'b0;
      if (t.escape_phase != fud_pkg::ESC_NONE || t.utf8_remaining != 2'd0) begin
         t.error_status = fud_pkg::ST_MALFORMED;
      end
      t.escape_phase      = fud_pkg::ESC_NONE;
      t.utf8_remaining    = 2'd0;
      t.utf8_length       = 2'd0;
      t.partial_codepoint = '0;
      full = (fud_pkg::CMP_WIDTH'(t.fields_taken) >= fud_pkg::CMP_WIDTH'(limit)) ||
             (&t.fields_taken);
      if (t.error_status == fud_pkg::ST_VALID) begin
         if (t.key_nonempty && full) begin
            t.error_status = fud_pkg::ST_TOO_MANY;
         end else begin
            if (t.key_nonempty) begin
               t.fields_taken = t.fields_taken + 1'b1;
               emit           = 1'b1;
            end
            t.component_part   = fud_pkg::PART_KEY;
            t.key_nonempty     = 1'b0;
            t.field_suppressed = 1'b0;
         end
      end
      return t;
   endfunction

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_stall  = (count_ff > CNT_W'(QDEPTH - MAXRES));
   assign csr_ready  = 1'b1;
   assign rsp_valid  = (count_ff != '0);
   assign rsp_payload = queue_ff[rd_ptr_ff];

   // decode one item
   always_comb begin
      fud_pkg::body_state_type s;
      logic [7:0]              b;
      logic [7:0]              d;
      logic                    dlv;
      logic                    do_close;
      logic                    emit;
      logic [4:0]              h;
      logic                    ok;
      s        = state_ff;
      b        = req_payload.body_byte;
      d        = b;
      dlv      = 1'b0;
      do_close = 1'b0;
      emit     = 1'b0;
      h        = fud_pkg::hex_digit(b);
      ok       = 1'b1;
      res_n    = 2'd0;
      for (int i = 0; i < MAXRES; i++) begin
         res[i] = '0;
      end

      if (req_payload.byte_present && s.error_status == fud_pkg::ST_VALID) begin
         if (s.escape_phase != fud_pkg::ESC_NONE) begin
            if (h[4]) begin
               s.error_status = fud_pkg::ST_MALFORMED;
            end else if (s.escape_phase == fud_pkg::ESC_HIGH) begin
               s.high_nibble  = h[3:0];
               s.escape_phase = fud_pkg::ESC_LOW;
            end else begin
               s.escape_phase = fud_pkg::ESC_NONE;
               d              = {s.high_nibble, h[3:0]};
               dlv            = 1'b1;
            end
         end else if (b == fud_pkg::CH_AMP) begin
            do_close = 1'b1;
         end else if (b == fud_pkg::CH_EQUAL && s.component_part == fud_pkg::PART_KEY) begin
            if (s.escape_phase != fud_pkg::ESC_NONE || s.utf8_remaining != 2'd0) begin
               s.error_status = fud_pkg::ST_MALFORMED;
            end
            s.escape_phase      = fud_pkg::ESC_NONE;
            s.utf8_remaining    = 2'd0;
            s.utf8_length       = 2'd0;
            s.partial_codepoint = '0;
            if (s.error_status == fud_pkg::ST_VALID) begin
               s.component_part   = fud_pkg::PART_VALUE;
               s.field_suppressed = !s.key_nonempty;
            end
         end else if (b == fud_pkg::CH_PERCENT) begin
            s.escape_phase = fud_pkg::ESC_HIGH;
         end else if (b == fud_pkg::CH_PLUS) begin
            d   = fud_pkg::CH_SPACE;
            dlv = 1'b1;
         end else begin
            dlv = 1'b1;
         end
      end

      // utf-8 text check of the decoded byte
      if (dlv) begin
         if (s.utf8_remaining == 2'd0) begin
            if ((d < 8'h20 && d != 8'h09 && d != 8'h0a && d != 8'h0d) || d == 8'h7f) begin
               ok = 1'b0;
            end else if (d[7] == 1'b0) begin
               ok = 1'b1;
            end else if (d[7:5] == 3'b110) begin
               s.utf8_length       = 2'd1;
               s.partial_codepoint = 21'(d[4:0]);
            end else if (d[7:4] == 4'b1110) begin
               s.utf8_length       = 2'd2;
               s.partial_codepoint = 21'(d[3:0]);
            end else if (d[7:3] == 5'b11110) begin
               s.utf8_length       = 2'd3;
               s.partial_codepoint = 21'(d[2:0]);
            end else begin
               ok = 1'b0;
            end
            if (ok && d[7]) begin
               s.utf8_remaining = s.utf8_length;
            end
         end else if (d[7:6] != 2'b10) begin
            ok = 1'b0;
         end else begin
            s.partial_codepoint = {s.partial_codepoint[14:0], d[5:0]};
            s.utf8_remaining    = s.utf8_remaining - 1'b1;
            if (s.utf8_remaining == 2'd0) begin
               if ((s.utf8_length == 2'd1 && s.partial_codepoint < fud_pkg::CP_MIN_2) ||
                   (s.utf8_length == 2'd2 && s.partial_codepoint < fud_pkg::CP_MIN_3) ||
                   (s.utf8_length == 2'd3 && s.partial_codepoint < fud_pkg::CP_MIN_4) ||
                   (s.partial_codepoint >= fud_pkg::CP_SURR_LO &&
                    s.partial_codepoint <= fud_pkg::CP_SURR_HI) ||
                   s.partial_codepoint > fud_pkg::CP_MAX) begin
                  ok = 1'b0;
               end
            end
         end
         if (!ok) begin
            s.error_status = fud_pkg::ST_MALFORMED;
         end else if (s.component_part == fud_pkg::PART_KEY) begin
            s.key_nonempty = 1'b1;
            res[res_n]     = fud_pkg::make_rsp(fud_pkg::KIND_KEY, d, fud_pkg::ST_VALID, 1'b0);
            res_n          = res_n + 1'b1;
         end else if (!s.field_suppressed) begin
            res[res_n] = fud_pkg::make_rsp(fud_pkg::KIND_VALUE, d, fud_pkg::ST_VALID, 1'b0);
            res_n      = res_n + 1'b1;
         end
      end

      if (do_close) begin
         s = close_field(s, field_limit_ff, emit);
         if (emit) begin
            res[res_n] = fud_pkg::make_rsp(fud_pkg::KIND_FIELD_END, 8'h00,
                                           fud_pkg::ST_VALID, 1'b0);
            res_n      = res_n + 1'b1;
         end
      end

      if (req_payload.end_of_body) begin
         if (s.error_status == fud_pkg::ST_VALID) begin
            s = close_field(s, field_limit_ff, emit);
            if (emit) begin
               res[res_n] = fud_pkg::make_rsp(fud_pkg::KIND_FIELD_END, 8'h00,
                                              fud_pkg::ST_VALID, 1'b0);
               res_n      = res_n + 1'b1;
            end
         end
         res[res_n] = fud_pkg::make_rsp(fud_pkg::KIND_STATUS, 8'h00, s.error_status, 1'b1);
         res_n      = res_n + 1'b1;
         s          = '0;
      end

      state_in = req_accept ? s : state_ff;
   end

   // output queue pointers
   always_comb begin
      logic [CNT_W-1:0] pushed;
      pushed    = req_accept ? CNT_W'(res_n) : '0;
      wr_ptr_in = wr_ptr_ff + PTR_W'(pushed);
      rd_ptr_in = rd_ptr_ff + PTR_W'(rsp_accept);
      count_in  = count_ff + pushed - CNT_W'(rsp_accept);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_limit_ff <= fud_pkg::FIELD_LIMIT_RESET;
         state_ff       <= '0;
         rd_ptr_ff      <= '0;
         wr_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            field_limit_ff <= csr_data;
         end
         state_ff  <= state_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAXRES; i++) begin
         if (req_accept && (2'(i) < res_n)) begin
            queue_ff[wr_ptr_ff + PTR_W'(i)] <= res[i];
         end
      end
   end

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QDEPTH))
      else $error("output queue over capacity");

   a_body_end_out: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_payload.end_of_body |=> rsp_valid)
      else $error("no result queued after body end");

   a_body_state_clear: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_payload.end_of_body |=>
         state_ff.fields_taken == '0 && state_ff.error_status == fud_pkg::ST_VALID)
      else $error("body state not cleared after body end");

   a_last_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last_result |-> rsp_payload.item_kind == fud_pkg::KIND_STATUS)
      else $error("last result is not a status item");
`endif

endmodule
